// ----- src/wpp_pkg.sv -----
`timescale 1ns / 1ps

package wpp_pkg;

   // sizing defaults
   localparam int MAX_CHANNELS_DEF = 8;
   localparam int QUEUE_DEPTH      = 4;

   // chunk ids as they sit in the id shift register after four bytes
   localparam logic [31:0] ID_RIFF = 32'h4646_4952;
   localparam logic [31:0] ID_WAVE = 32'h4556_4157;
   localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
   localparam logic [31:0] ID_DATA = 32'h6174_6164;

   localparam logic [15:0] FORMAT_PCM   = 16'd1;
   localparam logic [4:0]  ID_LEN       = 5'd4;
   localparam logic [4:0]  FMT_BODY_LEN = 5'd16;

   // byte positions inside the fmt body where a field completes
   localparam logic [4:0] FMT_POS_FORMAT   = 5'd1;
   localparam logic [4:0] FMT_POS_CHANNELS = 5'd3;
   localparam logic [4:0] FMT_POS_RATE     = 5'd7;
   localparam logic [4:0] FMT_POS_BITS     = 5'd15;

   localparam logic [15:0] BITS_8  = 16'd8;
   localparam logic [15:0] BITS_16 = 16'd16;
   localparam logic [15:0] BITS_32 = 16'd32;

   // error codes
   localparam logic [2:0] ERR_NONE    = 3'd0;
   localparam logic [2:0] ERR_NO_RIFF = 3'd1;
   localparam logic [2:0] ERR_NO_WAVE = 3'd2;
   localparam logic [2:0] ERR_FORMAT  = 3'd3;
   localparam logic [2:0] ERR_WIDTH   = 3'd4;

   // mono samples go out on these two channels
   localparam logic [2:0] CH_LEFT  = 3'd0;
   localparam logic [2:0] CH_RIGHT = 3'd1;

   typedef enum logic [3:0] {
      PH_RIFF,
      PH_RSIZE,
      PH_WAVE,
      PH_SUBID,
      PH_SZ_FMT,
      PH_SZ_DATA,
      PH_SZ_OTHER,
      PH_FMT_BODY,
      PH_SKIP,
      PH_DATA,
      PH_DONE,
      PH_ERROR
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       restart;
   } req_type;

   typedef struct packed {
      logic signed [31:0] sample;
      logic [2:0]         channel;
      logic [31:0]        sample_rate;
      logic [2:0]         error;
      logic               frame_end;
      logic               last;
   } rsp_type;

   // one entry per byte that causes results; dup marks a mono sample
   typedef struct packed {
      logic signed [31:0] sample;
      logic [2:0]         channel;
      logic [31:0]        sample_rate;
      logic [2:0]         error;
      logic               frame_end;
      logic               dup;
   } event_type;

   // odd chunk sizes carry one pad byte, except the all-ones size
   function automatic logic [31:0] padded_size(input logic [31:0] s);
      logic [31:0] r;
      r = s;
      if (s[0] && (s != 32'hFFFF_FFFF)) begin
         r = s + 32'd1;
      end
      return r;
   endfunction

endpackage

// ----- src/wpp_front.sv -----
`timescale 1ns / 1ps

module wpp_front
   import wpp_pkg::*;
#(
   parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      accept,
   input  req_type   item,
   output logic      ev_push,
   output event_type ev_data
);

   localparam int CIDX_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int CH_EXT_W = CIDX_W + 3;

   phase_type          phase_ff, phase_in, cur_phase;
   logic [4:0]         bi_ff, bi_in, cur_bi;
   logic [31:0]        rem_ff, rem_in, cur_rem;
   logic [31:0]        id_ff, id_in, cur_id;
   logic [15:0]        fmt_ff, fmt_in, cur_fmt;
   logic [15:0]        ch_ff, ch_in, cur_ch;
   logic [31:0]        rate_ff, rate_in, cur_rate;
   logic [15:0]        bits_ff, bits_in, cur_bits;
   logic               seen_ff, seen_in, cur_seen;
   logic [31:0]        asm_ff, asm_in, cur_asm;
   logic [CIDX_W-1:0]  chidx_ff, chidx_in, cur_chidx;

   logic [7:0]          b;
   logic [31:0]         shift_new;
   logic [4:0]          bi_inc;
   logic                hdr_done;
   logic                fmt_done;
   logic                smp_done;
   logic [31:0]         rem_dec;
   logic [31:0]         skip_cnt;
   logic [2:0]          data_err;
   logic [31:0]         asm_new;
   logic signed [31:0]  smp_val;
   logic                last_ch;
   logic [CH_EXT_W-1:0] chidx_ext;
   logic                emit;
   logic [2:0]          ev_err;
   logic signed [31:0]  ev_smp;
   logic [2:0]          ev_chan;
   logic                ev_fend;
   logic                ev_dup;

   // a restart byte sees the reset state
   assign b         = item.data_byte;
   assign cur_phase = item.restart ? PH_RIFF : phase_ff;
   assign cur_bi    = item.restart ? '0 : bi_ff;
   assign cur_rem   = item.restart ? '0 : rem_ff;
   assign cur_id    = item.restart ? '0 : id_ff;
   assign cur_fmt   = item.restart ? '0 : fmt_ff;
   assign cur_ch    = item.restart ? '0 : ch_ff;
   assign cur_rate  = item.restart ? '0 : rate_ff;
   assign cur_bits  = item.restart ? '0 : bits_ff;
   assign cur_seen  = item.restart ? 1'b0 : seen_ff;
   assign cur_asm   = item.restart ? '0 : asm_ff;
   assign cur_chidx = item.restart ? '0 : chidx_ff;

   // shared decode
   assign shift_new = {b, cur_id[31:8]};
   assign bi_inc    = cur_bi + 5'd1;
   assign hdr_done  = (bi_inc >= ID_LEN);
   assign fmt_done  = (bi_inc >= FMT_BODY_LEN);
   assign smp_done  = ({11'b0, bi_inc} >= (cur_bits >> 3));
   assign rem_dec   = cur_rem - 32'd1;
   assign skip_cnt  = (cur_rem > 32'd16) ? (cur_rem - 32'd16) : 32'd0;

   // format check at the end of the data header
   always_comb begin
      data_err = ERR_NONE;
      if (!cur_seen || (cur_fmt != FORMAT_PCM)) begin
         data_err = ERR_FORMAT;
      end else if (((cur_bits != BITS_8) && (cur_bits != BITS_16) && (cur_bits != BITS_32))
                   || (cur_ch == 16'd0) || (cur_ch > 16'(MAX_CHANNELS))) begin
         data_err = ERR_WIDTH;
      end
   end

   // little-endian sample assembly, one byte lane per byte
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         asm_new[8*k +: 8] = cur_asm[8*k +: 8] | ((cur_bi[1:0] == 2'(k)) ? b : 8'h00);
      end
   end

   // scale to q1.31
   always_comb begin
      case (cur_bits)
         BITS_8:  smp_val = {asm_new[7:0] ^ 8'h80, 24'h0};
         BITS_16: smp_val = {asm_new[15:0], 16'h0};
         default: smp_val = asm_new;
      endcase
   end

   assign last_ch   = ((17'(cur_chidx) + 17'd1) >= {1'b0, cur_ch});
   assign chidx_ext = CH_EXT_W'(cur_chidx);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         phase_in = cur_phase;
         case (cur_phase)
            PH_RIFF, PH_RSIZE, PH_WAVE, PH_SUBID, PH_SZ_FMT, PH_SZ_DATA, PH_SZ_OTHER: begin
               if (hdr_done) begin
                  case (cur_phase)
                     PH_RIFF:  phase_in = (shift_new == ID_RIFF) ? PH_RSIZE : PH_ERROR;
                     PH_RSIZE: phase_in = PH_WAVE;
                     PH_WAVE:  phase_in = (shift_new == ID_WAVE) ? PH_SUBID : PH_ERROR;
                     PH_SUBID: begin
                        if (shift_new == ID_FMT) begin
                           phase_in = PH_SZ_FMT;
                        end else if (shift_new == ID_DATA) begin
                           phase_in = PH_SZ_DATA;
                        end else begin
                           phase_in = PH_SZ_OTHER;
                        end
                     end
                     PH_SZ_FMT: phase_in = PH_FMT_BODY;
                     PH_SZ_OTHER: begin
                        phase_in = (padded_size(shift_new) == 32'd0) ? PH_SUBID : PH_SKIP;
                     end
                     PH_SZ_DATA: begin
                        if (data_err != ERR_NONE) begin
                           phase_in = PH_ERROR;
                        end else begin
                           phase_in = (shift_new == 32'd0) ? PH_DONE : PH_DATA;
                        end
                     end
                     default: phase_in = cur_phase;
                  endcase
               end
            end
            PH_FMT_BODY: begin
               if (fmt_done) begin
                  phase_in = (skip_cnt == 32'd0) ? PH_SUBID : PH_SKIP;
               end
            end
            PH_SKIP: phase_in = (rem_dec == 32'd0) ? PH_SUBID : PH_SKIP;
            PH_DATA: phase_in = (rem_dec == 32'd0) ? PH_DONE : PH_DATA;
            default: phase_in = cur_phase;
         endcase
      end
   end

   // datapath and result events
   always_comb begin
      bi_in    = bi_ff;
      rem_in   = rem_ff;
      id_in    = id_ff;
      fmt_in   = fmt_ff;
      ch_in    = ch_ff;
      rate_in  = rate_ff;
      bits_in  = bits_ff;
      seen_in  = seen_ff;
      asm_in   = asm_ff;
      chidx_in = chidx_ff;
      emit     = 1'b0;
      ev_err   = ERR_NONE;
      ev_smp   = '0;
      ev_chan  = CH_LEFT;
      ev_fend  = 1'b0;
      ev_dup   = 1'b0;
      if (accept) begin
         bi_in    = cur_bi;
         rem_in   = cur_rem;
         id_in    = cur_id;
         fmt_in   = cur_fmt;
         ch_in    = cur_ch;
         rate_in  = cur_rate;
         bits_in  = cur_bits;
         seen_in  = cur_seen;
         asm_in   = cur_asm;
         chidx_in = cur_chidx;
         case (cur_phase)
            PH_RIFF, PH_RSIZE, PH_WAVE, PH_SUBID, PH_SZ_FMT, PH_SZ_DATA, PH_SZ_OTHER: begin
               id_in = shift_new;
               bi_in = hdr_done ? 5'd0 : bi_inc;
               if (hdr_done) begin
                  case (cur_phase)
                     PH_RIFF: begin
                        if (shift_new != ID_RIFF) begin
                           emit   = 1'b1;
                           ev_err = ERR_NO_RIFF;
                        end
                     end
                     PH_WAVE: begin
                        if (shift_new != ID_WAVE) begin
                           emit   = 1'b1;
                           ev_err = ERR_NO_WAVE;
                        end
                     end
                     PH_SZ_FMT, PH_SZ_OTHER: rem_in = padded_size(shift_new);
                     PH_SZ_DATA: begin
                        if (data_err != ERR_NONE) begin
                           emit   = 1'b1;
                           ev_err = data_err;
                        end else begin
                           rem_in   = shift_new;
                           asm_in   = '0;
                           chidx_in = '0;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            PH_FMT_BODY: begin
               id_in = shift_new;
               case (cur_bi)
                  FMT_POS_FORMAT:   fmt_in  = shift_new[31:16];
                  FMT_POS_CHANNELS: ch_in   = shift_new[31:16];
                  FMT_POS_RATE:     rate_in = shift_new;
                  FMT_POS_BITS:     bits_in = shift_new[31:16];
                  default: begin
                  end
               endcase
               bi_in = fmt_done ? 5'd0 : bi_inc;
               if (fmt_done) begin
                  seen_in = 1'b1;
                  rem_in  = skip_cnt;
               end
            end
            PH_SKIP: rem_in = rem_dec;
            PH_DATA: begin
               rem_in = rem_dec;
               if (smp_done) begin
                  emit   = 1'b1;
                  ev_smp = smp_val;
                  bi_in  = 5'd0;
                  asm_in = '0;
                  if (cur_ch == 16'd1) begin
                     ev_dup = 1'b1;
                  end else begin
                     ev_chan  = chidx_ext[2:0];
                     ev_fend  = last_ch;
                     chidx_in = last_ch ? '0 : CIDX_W'(17'(cur_chidx) + 17'd1);
                  end
               end else begin
                  bi_in  = bi_inc;
                  asm_in = asm_new;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign ev_push             = accept && emit;
   assign ev_data.sample      = ev_smp;
   assign ev_data.channel     = ev_chan;
   assign ev_data.sample_rate = cur_rate;
   assign ev_data.error       = ev_err;
   assign ev_data.frame_end   = ev_fend;
   assign ev_data.dup         = ev_dup;

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_RIFF;
         bi_ff    <= '0;
         rem_ff   <= '0;
         id_ff    <= '0;
         fmt_ff   <= '0;
         ch_ff    <= '0;
         rate_ff  <= '0;
         bits_ff  <= '0;
         seen_ff  <= 1'b0;
         asm_ff   <= '0;
         chidx_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         bi_ff    <= bi_in;
         rem_ff   <= rem_in;
         id_ff    <= id_in;
         fmt_ff   <= fmt_in;
         ch_ff    <= ch_in;
         rate_ff  <= rate_in;
         bits_ff  <= bits_in;
         seen_ff  <= seen_in;
         asm_ff   <= asm_in;
         chidx_ff <= chidx_in;
      end
   end

endmodule

// ----- src/wpp_queue.sv -----
`timescale 1ns / 1ps

module wpp_queue
   import wpp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      wr_en,
   input  event_type wr_data,
   output logic      full,
   input  logic      rd_en,
   output event_type rd_data,
   output logic      empty
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   event_type        slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;

   assign full    = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_en ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = rd_en ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (!wr_en && rd_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ----- src/wpp_back.sv -----
`timescale 1ns / 1ps

module wpp_back
   import wpp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      q_empty,
   input  event_type q_data,
   output logic      q_pop,
   output logic      rsp_empty,
   input  logic      rsp_pop,
   output rsp_type   rsp_item
);

   logic    valid_ff, valid_in;
   logic    dup_ff, dup_in;
   rsp_type out_ff, out_in;
   logic    advance;

   assign advance   = !valid_ff || rsp_pop;
   assign rsp_empty = !valid_ff;
   assign rsp_item  = out_ff;

   // output register load: second half of a mono sample first, else next event
   always_comb begin
      valid_in = valid_ff;
      dup_in   = dup_ff;
      out_in   = out_ff;
      q_pop    = 1'b0;
      if (advance) begin
         if (dup_ff) begin
            out_in.channel   = CH_RIGHT;
            out_in.frame_end = 1'b1;
            out_in.last      = 1'b1;
            dup_in           = 1'b0;
            valid_in         = 1'b1;
         end else if (!q_empty) begin
            q_pop              = 1'b1;
            out_in.sample      = q_data.sample;
            out_in.sample_rate = q_data.sample_rate;
            out_in.error       = q_data.error;
            out_in.channel     = q_data.dup ? CH_LEFT : q_data.channel;
            out_in.frame_end   = q_data.dup ? 1'b0 : q_data.frame_end;
            out_in.last        = !q_data.dup;
            dup_in             = q_data.dup;
            valid_in           = 1'b1;
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         dup_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         dup_ff   <= dup_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

endmodule

// ----- src/wav_pcm_stream_parser_top.sv -----
`timescale 1ns / 1ps

// channel   ports                      accepted when
// input     push, full, req_item       push && !full
// result    empty, pop, rsp_item       pop && !empty
//
// one byte per cycle while full is low; the parser state machine handles each byte in the cycle it is taken
// a result goes from the parser into the event queue, then into the output register that drives rsp_item
// a mono sample gives two results from one byte; the output register sends one per
// cycle while pop is high, so a run of 8-bit mono data can fill the queue and raise full
// full rises when the four-entry event queue between parser and output fills
// reset is synchronous and clears parser state, queue pointers and output valid; no clearing pass

module wav_pcm_stream_parser_top
   import wpp_pkg::*;
#(
   parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_item,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_item
);

   logic      accept;
   logic      ev_push;
   event_type ev_data;
   logic      q_full;
   logic      q_empty;
   logic      q_pop;
   event_type q_data;

   assign full   = q_full;
   assign accept = push && !q_full;

   // parser front
   wpp_front #(
      .MAX_CHANNELS(MAX_CHANNELS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .item    (req_item),
      .ev_push (ev_push),
      .ev_data (ev_data)
   );

   // event queue
   wpp_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (ev_push),
      .wr_data (ev_data),
      .full    (q_full),
      .rd_en   (q_pop),
      .rd_data (q_data),
      .empty   (q_empty)
   );

   // result back end
   wpp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .rsp_empty (empty),
      .rsp_pop   (pop),
      .rsp_item  (rsp_item)
   );

`ifndef SYNTH
   // the parser never writes an event into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(ev_push && q_full))
      else $error("event pushed into full queue");

   // an error item carries no sample and ends its byte
   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_item.error != ERR_NONE)) |->
         (rsp_item.last && (rsp_item.sample == 32'sd0) && !rsp_item.frame_end))
      else $error("malformed error item");

   // left half of a mono sample is followed by its right half
   a_mono_pair: assert property (@(posedge clock) disable iff (reset)
      (!empty && pop && !rsp_item.last) |=>
         (!empty && (rsp_item.channel == CH_RIGHT) && rsp_item.last && rsp_item.frame_end))
      else $error("mono right half missing");
`endif

endmodule

// ----- test/wpp_stream_checker.sv -----
`timescale 1ns / 1ps

module wpp_stream_checker
   import wpp_pkg::*;
#(
   parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  logic    full,
   input  req_type req_item,
   input  logic    empty,
   input  logic    pop,
   input  rsp_type rsp_item,
   output int      error_count,
   output int      results_owed
);

   // parser state as the block should hold it
   phase_type   phase;
   logic [4:0]  byte_idx;
   logic [31:0] remaining;
   logic [31:0] id_sh;
   logic [31:0] rate;
   logic [31:0] assembly;
   logic [15:0] fmt_code;
   logic [15:0] chan_cnt;
   logic [15:0] bits;
   logic        fmt_seen;
   logic [2:0]  chan_idx;

   // results predicted but not yet seen on the result channel
   rsp_type pending_results[$];

   initial begin
      error_count  = 0;
      results_owed = 0;
   end

   task automatic clear_parser();
      phase     = PH_RIFF;
      byte_idx  = '0;
      remaining = '0;
      id_sh     = '0;
      fmt_code  = '0;
      chan_cnt  = '0;
      rate      = '0;
      bits      = '0;
      fmt_seen  = 1'b0;
      assembly  = '0;
      chan_idx  = '0;
   endtask

   task automatic expect_result(input logic [31:0] smp, input logic [2:0] ch,
                                input logic [2:0] err, input logic fend, input logic lst);
      rsp_type r;
      r.sample      = smp;
      r.channel     = ch;
      r.sample_rate = rate;
      r.error       = err;
      r.frame_end   = fend;
      r.last        = lst;
      pending_results.push_back(r);
   endtask

   // an error gives one result and locks the parser until restart
   task automatic abort_file(input logic [2:0] code);
      phase = PH_ERROR;
      expect_result('0, '0, code, 1'b0, 1'b1);
   endtask

   // odd sizes carry a pad byte, the all-ones size does not
   function automatic logic [31:0] with_pad(input logic [31:0] s);
      return (s[0] && s != 32'hFFFF_FFFF) ? s + 32'd1 : s;
   endfunction

   task automatic begin_skip(input logic [31:0] count);
      remaining = count;
      phase     = (count == 0) ? PH_SUBID : PH_SKIP;
   endtask

   // one byte of the data chunk; emits when a sample is complete
   task automatic take_sample_byte(input logic [7:0] b);
      logic [15:0] need;
      logic [31:0] smp;
      logic        fend;
      need      = bits >> 3;
      assembly  = assembly | ({24'd0, b} << (8 * byte_idx[1:0]));
      byte_idx  = byte_idx + 5'd1;
      remaining = remaining - 32'd1;
      if ({11'd0, byte_idx} >= need) begin
         if (bits == BITS_8) begin
            smp = {~assembly[7], assembly[6:0], 24'd0};
         end else if (bits == BITS_16) begin
            smp = {assembly[15:0], 16'd0};
         end else begin
            smp = assembly;
         end
         if (chan_cnt == 16'd1) begin
            expect_result(smp, CH_LEFT, ERR_NONE, 1'b0, 1'b0);
            expect_result(smp, CH_RIGHT, ERR_NONE, 1'b1, 1'b1);
         end else begin
            fend = (int'(chan_idx) + 1 >= int'(chan_cnt));
            expect_result(smp, chan_idx, ERR_NONE, fend, 1'b1);
            chan_idx = fend ? 3'd0 : chan_idx + 3'd1;
         end
         byte_idx = '0;
         assembly = '0;
      end
      if (remaining == 0) begin
         phase = PH_DONE;
      end
   endtask

   // predict the effect of one accepted item
   task automatic parse_byte(input logic [7:0] b, input logic rst);
      if (rst) begin
         clear_parser();
      end
      case (phase)
         PH_RIFF, PH_RSIZE, PH_WAVE, PH_SUBID, PH_SZ_FMT, PH_SZ_DATA, PH_SZ_OTHER: begin
            id_sh    = {b, id_sh[31:8]};
            byte_idx = byte_idx + 5'd1;
            if (byte_idx >= ID_LEN) begin
               byte_idx = '0;
               case (phase)
                  PH_RIFF: begin
                     if (id_sh != ID_RIFF) abort_file(ERR_NO_RIFF);
                     else phase = PH_RSIZE;
                  end
                  PH_RSIZE: phase = PH_WAVE;
                  PH_WAVE: begin
                     if (id_sh != ID_WAVE) abort_file(ERR_NO_WAVE);
                     else phase = PH_SUBID;
                  end
                  PH_SUBID: begin
                     if (id_sh == ID_FMT) phase = PH_SZ_FMT;
                     else if (id_sh == ID_DATA) phase = PH_SZ_DATA;
                     else phase = PH_SZ_OTHER;
                  end
                  PH_SZ_FMT: begin
                     remaining = with_pad(id_sh);
                     phase     = PH_FMT_BODY;
                  end
                  PH_SZ_OTHER: begin_skip(with_pad(id_sh));
                  default: begin
                     // format is only judged once the data header is complete
                     if (!fmt_seen || fmt_code != FORMAT_PCM) begin
                        abort_file(ERR_FORMAT);
                     end else if ((bits != BITS_8 && bits != BITS_16 && bits != BITS_32) ||
                                  chan_cnt == 0 || chan_cnt > MAX_CHANNELS) begin
                        abort_file(ERR_WIDTH);
                     end else begin
                        remaining = id_sh;
                        assembly  = '0;
                        chan_idx  = '0;
                        phase     = (id_sh == 0) ? PH_DONE : PH_DATA;
                     end
                  end
               endcase
            end
         end
         PH_FMT_BODY: begin
            id_sh = {b, id_sh[31:8]};
            case (byte_idx)
               FMT_POS_FORMAT:   fmt_code = id_sh[31:16];
               FMT_POS_CHANNELS: chan_cnt = id_sh[31:16];
               FMT_POS_RATE:     rate     = id_sh;
               FMT_POS_BITS:     bits     = id_sh[31:16];
               default: ;
            endcase
            byte_idx = byte_idx + 5'd1;
            // sixteen body bytes are read whatever the chunk size says
            if (byte_idx >= FMT_BODY_LEN) begin
               byte_idx = '0;
               fmt_seen = 1'b1;
               begin_skip(remaining > 32'd16 ? remaining - 32'd16 : 32'd0);
            end
         end
         PH_SKIP: begin
            remaining = remaining - 32'd1;
            if (remaining == 0) phase = PH_SUBID;
         end
         PH_DATA: take_sample_byte(b);
         default: ;
      endcase
   endtask

   // compare one result against the oldest prediction
   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (pending_results.size() == 0) begin
         if (error_count < 10) begin
            $display("unexpected result: sample=%h channel=%0d rate=%h error=%0d fe=%0b last=%0b",
                     got.sample, got.channel, got.sample_rate, got.error, got.frame_end,
                     got.last);
         end
         error_count++;
      end else begin
         want = pending_results.pop_front();
         if (got.sample !== want.sample || got.channel !== want.channel ||
             got.sample_rate !== want.sample_rate || got.error !== want.error ||
             got.frame_end !== want.frame_end || got.last !== want.last) begin
            if (error_count < 10) begin
               $display("result mismatch: expected sample=%h channel=%0d rate=%h error=%0d",
                        want.sample, want.channel, want.sample_rate, want.error,
                        " fe=%0b last=%0b", want.frame_end, want.last);
               $display("                 actual   sample=%h channel=%0d rate=%h error=%0d",
                        got.sample, got.channel, got.sample_rate, got.error,
                        " fe=%0b last=%0b", got.frame_end, got.last);
            end
            error_count++;
         end
      end
   endtask

   // watch both channels at each edge
   always @(posedge clock) begin
      if (reset) begin
         clear_parser();
         pending_results.delete();
      end else begin
         if (push && !full) parse_byte(req_item.data_byte, req_item.restart);
         if (pop && !empty) check_result(rsp_item);
      end
      results_owed = pending_results.size();
   end

endmodule

// ----- test/wav_pcm_stream_parser_top_tb.sv -----
`timescale 1ns / 1ps

module wav_pcm_stream_parser_top_tb;
   import wpp_pkg::*;

   localparam int BYTE_TARGET = 1150;
   localparam int CYCLE_LIMIT = 400000;

   logic    clock;
   logic    reset    = 1'b1;
   logic    push     = 1'b0;
   logic    pop      = 1'b0;
   req_type req_item = '0;
   logic    full;
   logic    empty;
   rsp_type rsp_item;

   int error_count;
   int results_owed;
   int cycle_count = 0;
   int burst_left  = 0;
   int bytes_sent  = 0;

   // bytes of the file being built
   logic [7:0] file_bytes[$];

   wav_pcm_stream_parser_top dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_item (req_item),
      .empty    (empty),
      .pop      (pop),
      .rsp_item (rsp_item)
   );

   wpp_stream_checker stream_check (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .req_item     (req_item),
      .empty        (empty),
      .pop          (pop),
      .rsp_item     (rsp_item),
      .error_count  (error_count),
      .results_owed (results_owed)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("wav_pcm_stream_parser_top_tb failed");
      $finish;
   end

   // receiver: stall pattern switches among three modes chosen at random
   initial begin
      int mode       = 0;
      int mode_left  = 0;
      int stall_left = 0;
      forever begin
         @(posedge clock);
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 2);
            mode_left = $urandom_range(50, 300);
         end
         mode_left--;
         if (stall_left > 0) begin
            stall_left--;
            pop <= 1'b0;
         end else if (mode == 1 && $urandom_range(0, 1) == 0) begin
            stall_left = $urandom_range(0, 2);
            pop <= 1'b0;
         end else if (mode == 2 && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(4, 19);
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   // sender: bursts of items with random gaps between them
   task automatic send_byte(input logic [7:0] b, input logic first);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 24);
      end
      req_item <= '{data_byte: b, restart: first};
      push     <= 1'b1;
      do @(posedge clock); while (full);
      burst_left--;
      bytes_sent++;
   endtask

   // first byte of each file carries restart
   task automatic send_file();
      for (int i = 0; i < file_bytes.size(); i++) begin
         send_byte(file_bytes[i], i == 0);
      end
      file_bytes.delete();
   endtask

   task automatic put_le(input logic [31:0] v, input int n);
      for (int i = 0; i < n; i++) begin
         file_bytes.push_back(v[8*i +: 8]);
      end
   endtask

   // random bytes leaning toward the sample extremes
   task automatic put_noise(input int n);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 7))
            0:       file_bytes.push_back(8'h00);
            1:       file_bytes.push_back(8'hFF);
            2:       file_bytes.push_back(8'h80);
            3:       file_bytes.push_back(8'h7F);
            default: file_bytes.push_back(8'($urandom));
         endcase
      end
   endtask

   task automatic put_head(input logic [31:0] riff_id, input logic [31:0] wave_id);
      put_le(riff_id, 4);
      put_le($urandom, 4);
      put_le(wave_id, 4);
   endtask

   // fmt chunk: sixteen body bytes, then any extra bytes and pad
   task automatic put_fmt(input logic [31:0] size, input logic [15:0] fcode,
                          input logic [15:0] chans, input logic [31:0] rate_v,
                          input logic [15:0] bits_v);
      put_le(ID_FMT, 4);
      put_le(size, 4);
      put_le(fcode, 2);
      put_le(chans, 2);
      put_le(rate_v, 4);
      put_le($urandom, 4);
      put_le($urandom, 2);
      put_le(bits_v, 2);
      if (size > 32'd16) put_noise(int'(size - 32'd16) + int'(size[0]));
   endtask

   task automatic put_chunk(input logic [31:0] cid, input logic [31:0] size);
      put_le(cid, 4);
      put_le(size, 4);
      put_noise(int'(size) + int'(size[0]));
   endtask

   task automatic put_data_head(input logic [31:0] size);
      put_le(ID_DATA, 4);
      put_le(size, 4);
   endtask

   // mostly well-formed files with random content, some broken or cut short
   task automatic make_random_file();
      int          kind;
      int          chans;
      int          width;
      int          frames;
      int          size_v;
      int          keep;
      logic [15:0] fcode;
      logic [15:0] chans_f;
      logic [15:0] bits_f;
      logic [31:0] rate_v;
      logic        skip_fmt;
      kind = $urandom_range(0, 99);
      if (kind < 6) begin
         put_noise($urandom_range(1, 10));
      end else if (kind < 14) begin
         if ($urandom_range(0, 1) == 0) begin
            put_head(ID_RIFF ^ (32'd1 << $urandom_range(0, 31)), ID_WAVE);
         end else begin
            put_head(ID_RIFF, ID_WAVE ^ (32'd1 << $urandom_range(0, 31)));
         end
         put_noise($urandom_range(0, 6));
      end else begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: chans = 1;
            4, 5, 6:    chans = 2;
            default:    chans = $urandom_range(3, 8);
         endcase
         case ($urandom_range(0, 2))
            0:       width = 1;
            1:       width = 2;
            default: width = 4;
         endcase
         case ($urandom_range(0, 7))
            0:       rate_v = 32'd0;
            1:       rate_v = 32'hFFFF_FFFF;
            default: rate_v = $urandom;
         endcase
         fcode    = FORMAT_PCM;
         chans_f  = 16'(chans);
         bits_f   = 16'(width * 8);
         skip_fmt = 1'b0;
         frames   = $urandom_range(0, (chans > 2) ? 2 : 5);
         size_v   = frames * chans * width;
         if ($urandom_range(0, 9) == 0) size_v += $urandom_range(1, 3);
         if (kind < 30) begin
            case ($urandom_range(0, 3))
               0: fcode = 16'($urandom);
               1: bits_f = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                       : 16'($urandom_range(0, 40));
               2: chans_f = ($urandom_range(0, 1) == 0) ? 16'd0
                                                        : 16'($urandom_range(9, 65535));
               default: skip_fmt = 1'b1;
            endcase
            size_v = $urandom_range(0, 8);
         end
         put_head(ID_RIFF, ID_WAVE);
         repeat ($urandom_range(0, 2)) put_chunk($urandom, $urandom_range(0, 7));
         if (!skip_fmt) begin
            put_fmt(($urandom_range(0, 4) == 0) ? $urandom_range(12, 23) : 16,
                    fcode, chans_f, rate_v, bits_f);
         end
         if ($urandom_range(0, 3) == 0) put_chunk($urandom, $urandom_range(0, 5));
         put_data_head(size_v);
         put_noise(size_v + $urandom_range(0, 3));
         // cut the file short so that the next one restarts mid-stream
         if ($urandom_range(0, 6) == 0) begin
            keep = $urandom_range(1, file_bytes.size() - 1);
            while (file_bytes.size() > keep) void'(file_bytes.pop_back());
         end
      end
   endtask

   // stimulus and verdict
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // missing riff id
      put_head(ID_RIFF ^ 32'h1, ID_WAVE);
      put_noise(4);
      send_file();
      // missing wave id
      put_head(ID_RIFF, ID_WAVE ^ 32'h0100_0000);
      put_noise(3);
      send_file();
      // data before fmt
      put_head(ID_RIFF, ID_WAVE);
      put_data_head(4);
      put_noise(4);
      send_file();
      // format code other than pcm
      put_head(ID_RIFF, ID_WAVE);
      put_fmt(16, 16'd3, 16'd2, 32'd48000, BITS_16);
      put_data_head(4);
      send_file();
      // unsupported width
      put_head(ID_RIFF, ID_WAVE);
      put_fmt(16, FORMAT_PCM, 16'd2, 32'd44100, 16'd24);
      put_data_head(6);
      send_file();
      // zero channels, then too many channels
      put_head(ID_RIFF, ID_WAVE);
      put_fmt(16, FORMAT_PCM, 16'd0, 32'd22050, BITS_16);
      put_data_head(4);
      send_file();
      put_head(ID_RIFF, ID_WAVE);
      put_fmt(16, FORMAT_PCM, 16'd9, 32'd22050, BITS_8);
      put_data_head(4);
      send_file();
      // 8-bit mono extremes, bytes after the data chunk are ignored
      put_head(ID_RIFF, ID_WAVE);
      put_fmt(16, FORMAT_PCM, 16'd1, 32'd8000, BITS_8);
      put_data_head(4);
      put_le(32'h7F80_FF00, 4);
      put_noise(3);
      send_file();
      // odd unknown chunk, long odd fmt, 16-bit stereo extremes, partial sample dropped
      put_head(ID_RIFF, ID_WAVE);
      put_chunk(32'h5453_494C, 3);
      put_fmt(19, FORMAT_PCM, 16'd2, 32'hFFFF_FFFF, BITS_16);
      put_data_head(9);
      put_le(32'h7FFF_8000, 4);
      put_le(32'hFFFF_0000, 4);
      put_noise(1);
      send_file();
      // short fmt, 32-bit three channels, partial frame emitted
      put_head(ID_RIFF, ID_WAVE);
      put_fmt(14, FORMAT_PCM, 16'd3, 32'd0, BITS_32);
      put_data_head(20);
      put_le(32'h8000_0000, 4);
      put_le(32'h7FFF_FFFF, 4);
      put_le(32'h0000_0000, 4);
      put_le(32'hFFFF_FFFF, 4);
      put_le(32'h1234_5678, 4);
      send_file();
      // empty data chunk ends at once
      put_head(ID_RIFF, ID_WAVE);
      put_chunk(32'h6B6E_756A, 0);
      put_fmt(16, FORMAT_PCM, 16'd2, 32'd96000, BITS_16);
      put_data_head(0);
      put_noise(4);
      send_file();
      // unknown chunk of all-ones size, left by restart
      put_head(ID_RIFF, ID_WAVE);
      put_le(32'h7473_6574, 4);
      put_le(32'hFFFF_FFFF, 4);
      put_noise(6);
      send_file();
      // eight channels of 8-bit data
      put_head(ID_RIFF, ID_WAVE);
      put_fmt(16, FORMAT_PCM, 16'd8, 32'd16000, BITS_8);
      put_data_head(10);
      put_noise(10);
      send_file();
      // restart in the middle of a long data chunk and of a header
      put_head(ID_RIFF, ID_WAVE);
      put_fmt(16, FORMAT_PCM, 16'd2, 32'd32000, BITS_16);
      put_data_head(1000);
      put_noise(5);
      send_file();
      put_le(ID_RIFF, 4);
      put_noise(2);
      send_file();

      // random files fill up the rest of the byte budget
      while (bytes_sent < BYTE_TARGET) begin
         make_random_file();
         send_file();
      end
      push <= 1'b0;

      // drain and let any stray result show
      @(posedge clock);
      wait (results_owed == 0);
      repeat (10) @(posedge clock);
      if (error_count == 0 && results_owed == 0) begin
         $display("wav_pcm_stream_parser_top_tb passed");
      end else begin
         $display("wav_pcm_stream_parser_top_tb failed");
      end
      $finish;
   end

endmodule
